[src/acpt_pkg.sv]
// shared types and constants for the contact pair tracker
`default_nettype none

package acpt_pkg;

    // stream widths
    localparam int ID_W     = 32;
    localparam int COORD_W  = 16;
    localparam int KEY_W    = 2 * ID_W;
    localparam int S_DATA_W = 192;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 8;
    localparam int M_USER_W = 1;
    localparam int EVENT_W  = 2;

    // contact event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } event_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_CMP,
        ST_MISS,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic scan_clr;
        logic scan_inc;
        logic rd;
        logic upd;
        logic ins;
        logic res_none;
        logic res_full;
        logic emit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic ids_equal;
        logic fill_zero;
        logic fill_full;
        logic key_match;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

[src/acpt_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module acpt_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/acpt_ctrl.sv]
// controller state machine for the contact pair tracker
`default_nettype none

module acpt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire acpt_pkg::sts_t sts,
    output acpt_pkg::cmd_t     cmd
);

    import acpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.prep     = 1'b1;
                cmd.scan_clr = 1'b1;
                if (sts.ids_equal)
                begin
                    cmd.res_none = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (sts.fill_zero)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (sts.key_match)
                begin
                    cmd.upd    = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_MISS:
            begin
                if (sts.fill_full)
                begin
                    cmd.res_full = 1'b1;
                end
                else
                begin
                    cmd.ins = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/acpt_dpath.sv]
// datapath: input capture, overlap test, pair table and output register
`default_nettype none

module acpt_dpath #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire acpt_pkg::cmd_t                cmd,
    output acpt_pkg::sts_t                     sts,
    input  wire logic [acpt_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [acpt_pkg::S_USER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [acpt_pkg::M_DATA_W-1:0] m_tdata,
    output logic      [acpt_pkg::M_USER_W-1:0] m_tuser
);

    import acpt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ROW_W = KEY_W + 1;
    localparam int AD_W  = COORD_W + 1;

    // captured transaction
    logic [KEY_W-1:0]   key_reg;
    logic [COORD_W-1:0] lx_reg, ly_reg, lw_reg, lh_reg;
    logic [COORD_W-1:0] rx_reg, ry_reg, rw_reg, rh_reg;
    logic               dead_reg;

    // geometry stage
    logic [AD_W-1:0] adx_reg, ady_reg, sumx_reg, sumy_reg;
    logic signed [AD_W-1:0] dx, dy;
    logic            hit;

    // scan and fill counters
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] idx_inc;

    // table access
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic             contact_cur;
    logic             contact_new;
    event_t           ev;

    // result and output register
    event_t res_event_reg;
    logic   res_full_reg;
    logic   out_valid_reg, out_valid_next;
    event_t out_event_reg;
    logic   out_full_reg;

    // capture accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg  <= {s_tdata[63:32], s_tdata[31:0]};
            lx_reg   <= s_tdata[79:64];
            ly_reg   <= s_tdata[95:80];
            lw_reg   <= s_tdata[111:96];
            lh_reg   <= s_tdata[127:112];
            rx_reg   <= s_tdata[143:128];
            ry_reg   <= s_tdata[159:144];
            rw_reg   <= s_tdata[175:160];
            rh_reg   <= s_tdata[191:176];
            dead_reg <= s_tuser[0] | s_tuser[1];
        end
    end

    // center distance per axis
    assign dx = $signed({rx_reg[COORD_W-1], rx_reg}) - $signed({lx_reg[COORD_W-1], lx_reg});
    assign dy = $signed({ry_reg[COORD_W-1], ry_reg}) - $signed({ly_reg[COORD_W-1], ly_reg});

    // absolute distance and size sums
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            adx_reg  <= dx[AD_W-1] ? AD_W'(-dx) : AD_W'(dx);
            ady_reg  <= dy[AD_W-1] ? AD_W'(-dy) : AD_W'(dy);
            sumx_reg <= AD_W'(lw_reg) + AD_W'(rw_reg);
            sumy_reg <= AD_W'(lh_reg) + AD_W'(rh_reg);
        end
    end

    // strict overlap on both axes: 2*|d| < size sum
    assign hit = ({adx_reg, 1'b0} < {1'b0, sumx_reg}) &&
                 ({ady_reg, 1'b0} < {1'b0, sumy_reg});

    // counters
    assign idx_inc = CNT_W'(idx_reg) + CNT_W'(1);

    always_comb
    begin
        idx_next  = idx_reg;
        fill_next = fill_reg;
        if (cmd.scan_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_inc)
        begin
            idx_next = idx_inc[IDX_W-1:0];
        end
        if (cmd.ins)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            fill_reg <= fill_next;
        end
    end

    // event rules, a new entry starts out of contact
    assign contact_cur = cmd.ins ? 1'b0 : ram_rdata[KEY_W];

    always_comb
    begin
        ev          = EV_NONE;
        contact_new = 1'b0;
        if (hit)
        begin
            if (contact_cur)
            begin
                ev          = dead_reg ? EV_EXIT : EV_STAY;
                contact_new = !dead_reg;
            end
            else if (!dead_reg)
            begin
                ev          = EV_ENTER;
                contact_new = 1'b1;
            end
        end
        else if (contact_cur)
        begin
            ev = EV_EXIT;
        end
    end

    // pair table: contact bit above the key
    assign ram_we    = cmd.upd | cmd.ins;
    assign ram_waddr = cmd.ins ? fill_reg[IDX_W-1:0] : idx_reg;
    assign ram_wdata = {contact_new, key_reg};

    acpt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // result of the current transaction
    always_ff @(posedge clk)
    begin
        if (cmd.upd || cmd.ins)
        begin
            res_event_reg <= ev;
            res_full_reg  <= 1'b0;
        end
        else if (cmd.res_none)
        begin
            res_event_reg <= EV_NONE;
            res_full_reg  <= 1'b0;
        end
        else if (cmd.res_full)
        begin
            res_event_reg <= EV_NONE;
            res_full_reg  <= 1'b1;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_event_reg <= res_event_reg;
            out_full_reg  <= res_full_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_event_reg);
    assign m_tuser  = M_USER_W'(out_full_reg);

    // status to controller
    assign sts.ids_equal = (key_reg[KEY_W-1:ID_W] == key_reg[ID_W-1:0]);
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.fill_full = (fill_reg == CNT_W'(TABLE_ENTRIES));
    assign sts.key_match = (ram_rdata[KEY_W-1:0] == key_reg);
    assign sts.scan_last = (idx_inc == fill_reg);
    assign sts.out_free  = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

[src/aabb_contact_pair_tracker.sv]
// top level of the axis-aligned box contact pair tracker
`default_nettype none

// Each input transaction is one collider pair; it yields exactly one output
// transaction with an enter, stay, exit or none event and a table-full flag.
// Pairs are remembered in a table of TABLE_ENTRIES rows (key plus contact
// bit) held in a single-port-read RAM and searched linearly, each row by a
// read of its address, then a compare of the registered read data. A pair
// found at a scanned row updates it; a pair not found after scanning the
// filled rows gets a new insert or a table-full flag; a pair with equal
// IDs skips the scan. The next transaction is accepted only after the
// result has moved to the output register. Rows are filled in order and
// never freed, so the fill count alone marks the live rows and no clearing
// pass is needed after reset. The output register lets the next
// transaction be accepted while the previous result waits on m_tready.

module aabb_contact_pair_tracker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // left_id, right_id, left_x, left_y, left_width, left_height,
    // right_x, right_y, right_width, right_height
    input  wire logic [acpt_pkg::S_DATA_W-1:0] s_tdata,
    // left_dead, right_dead
    input  wire logic [acpt_pkg::S_USER_W-1:0] s_tuser,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // contact_event, zero padding
    output logic      [acpt_pkg::M_DATA_W-1:0] m_tdata,
    // table_full
    output logic      [acpt_pkg::M_USER_W-1:0] m_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);

    import acpt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // controller
    acpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    acpt_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a full-table result never carries an event
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[EVENT_W-1:0] == EV_NONE))
    else $error("table full result with an event");

    // one transaction in flight: no acceptance right after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("transaction accepted while busy");

    // inserts only into a table with a free row
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> !sts.fill_full)
    else $error("insert into full table");

    // results are only moved into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire

[test/tb_top.sv]
// testbench for the aabb contact pair tracker: directed and random pair streams
`timescale 1ns / 100ps

module tb_top;

    import acpt_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int POOL_SIZE     = 40;
    localparam int MAX_LATENCY   = 2 * TABLE_DEPTH + 3;

    // box geometry and ids, laid out exactly as s_tdata (left_id in the lowest bits)
    typedef struct packed {
        logic        [15:0] right_height;
        logic        [15:0] right_width;
        logic signed [15:0] right_y;
        logic signed [15:0] right_x;
        logic        [15:0] left_height;
        logic        [15:0] left_width;
        logic signed [15:0] left_y;
        logic signed [15:0] left_x;
        logic        [31:0] right_id;
        logic        [31:0] left_id;
    } pair_geom_t;

    typedef struct {
        pair_geom_t geom;
        logic       left_dead;
        logic       right_dead;
    } collider_pair_t;

    typedef struct {
        event_t ev;
        logic   full;
    } contact_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    // tracker shadow: keys in fill order plus their contact bits
    logic [63:0]     tracked_keys[$];
    logic            tracked_contact[$];
    contact_result_t expected_results[$];

    logic [31:0] pool_left[POOL_SIZE];
    logic [31:0] pool_right[POOL_SIZE];

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int sink_gap     = 0;
    int idle_cycles  = 0;
    int error_count  = 0;
    int pairs_sent   = 0;
    int events_seen[4];
    int full_flags   = 0;

    aabb_contact_pair_tracker #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // strict overlap on one axis: 2*|right - left| < left_size + right_size
    function automatic bit axis_hits(logic signed [15:0] lp, logic [15:0] ls,
                                     logic signed [15:0] rp, logic [15:0] rs);
        int gap;
        int span;
        gap  = $signed(rp) - $signed(lp);
        span = ls + rs;
        if (gap < 0)
            gap = -gap;
        return (2 * gap) < span;
    endfunction

    // expected event for one pair, updating the shadow table
    function automatic contact_result_t predict_contact(collider_pair_t p);
        contact_result_t r;
        logic [63:0]     key;
        int              slot;
        bit              hit;
        bit              dead;
        r.ev   = EV_NONE;
        r.full = 1'b0;
        if (p.geom.left_id == p.geom.right_id)
            return r;
        key  = {p.geom.right_id, p.geom.left_id};
        dead = p.left_dead | p.right_dead;
        slot = -1;
        foreach (tracked_keys[i])
            if (slot < 0 && tracked_keys[i] == key)
                slot = i;
        if (slot < 0)
        begin
            if (tracked_keys.size() >= TABLE_DEPTH)
            begin
                r.full = 1'b1;
                return r;
            end
            tracked_keys.push_back(key);
            tracked_contact.push_back(1'b0);
            slot = tracked_keys.size() - 1;
        end
        hit = axis_hits(p.geom.left_x, p.geom.left_width, p.geom.right_x,
                        p.geom.right_width)
            && axis_hits(p.geom.left_y, p.geom.left_height, p.geom.right_y,
                         p.geom.right_height);
        if (hit)
        begin
            if (tracked_contact[slot])
            begin
                if (dead)
                begin
                    r.ev = EV_EXIT;
                    tracked_contact[slot] = 1'b0;
                end
                else
                    r.ev = EV_STAY;
            end
            else if (!dead)
            begin
                r.ev = EV_ENTER;
                tracked_contact[slot] = 1'b1;
            end
        end
        else if (tracked_contact[slot])
        begin
            r.ev = EV_EXIT;
            tracked_contact[slot] = 1'b0;
        end
        return r;
    endfunction

    function automatic collider_pair_t build_pair(
        logic [31:0] lid, logic [31:0] rid,
        logic [15:0] lx, logic [15:0] ly, logic [15:0] lw, logic [15:0] lh,
        logic [15:0] rx, logic [15:0] ry, logic [15:0] rw, logic [15:0] rh,
        logic ldead, logic rdead);
        collider_pair_t p;
        p.geom.left_id      = lid;
        p.geom.right_id     = rid;
        p.geom.left_x       = lx;
        p.geom.left_y       = ly;
        p.geom.left_width   = lw;
        p.geom.left_height  = lh;
        p.geom.right_x      = rx;
        p.geom.right_y      = ry;
        p.geom.right_width  = rw;
        p.geom.right_height = rh;
        p.left_dead         = ldead;
        p.right_dead        = rdead;
        return p;
    endfunction

    // random boxes, mostly close together so contacts come and go
    function automatic collider_pair_t random_pair(logic [31:0] lid, logic [31:0] rid);
        collider_pair_t p;
        p.geom.left_id  = lid;
        p.geom.right_id = rid;
        p.geom.left_x   = 16'($urandom);
        p.geom.left_y   = 16'($urandom);
        if ($urandom_range(0, 9) < 7)
        begin
            p.geom.right_x = 16'(p.geom.left_x + $urandom_range(0, 512) - 256);
            p.geom.right_y = 16'(p.geom.left_y + $urandom_range(0, 512) - 256);
        end
        else
        begin
            p.geom.right_x = 16'($urandom);
            p.geom.right_y = 16'($urandom);
        end
        if ($urandom_range(0, 15) == 0)
        begin
            p.geom.left_width   = 16'($urandom);
            p.geom.left_height  = 16'($urandom);
            p.geom.right_width  = 16'($urandom);
            p.geom.right_height = 16'($urandom);
        end
        else
        begin
            p.geom.left_width   = 16'($urandom_range(0, 600));
            p.geom.left_height  = 16'($urandom_range(0, 600));
            p.geom.right_width  = 16'($urandom_range(0, 600));
            p.geom.right_height = 16'($urandom_range(0, 600));
        end
        p.left_dead  = ($urandom_range(0, 7) == 0);
        p.right_dead = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    // send one pair and record its expected result at acceptance
    task automatic send_pair(collider_pair_t p);
        if (src_idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tdata  <= p.geom;
        s_tuser  <= {p.right_dead, p.left_dead};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        expected_results.push_back(predict_contact(p));
        pairs_sent++;
    endtask

    // stop sending and wait until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // equal ids, id order, every event rule, strict boundaries, field extremes
    task automatic test_directed();
        send_pair(build_pair(32'h1234, 32'h1234, 0, 0, 100, 100, 0, 0, 100, 100, 0, 0));
        send_pair(build_pair(32'h0, 32'h0, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 1, 1, 1, 1));
        // enter, stay, dead exit, dead none, enter, separation exit, none
        send_pair(build_pair(32'h0, 32'hFFFF_FFFF, 0, 0, 64, 64, 16, 16, 64, 64, 0, 0));
        send_pair(build_pair(32'h0, 32'hFFFF_FFFF, 0, 0, 64, 64, 16, 16, 64, 64, 0, 0));
        send_pair(build_pair(32'h0, 32'hFFFF_FFFF, 0, 0, 64, 64, 16, 16, 64, 64, 1, 0));
        send_pair(build_pair(32'h0, 32'hFFFF_FFFF, 0, 0, 64, 64, 16, 16, 64, 64, 0, 1));
        send_pair(build_pair(32'h0, 32'hFFFF_FFFF, 0, 0, 64, 64, 16, 16, 64, 64, 0, 0));
        send_pair(build_pair(32'h0, 32'hFFFF_FFFF, 0, 0, 64, 64, 500, 16, 64, 64, 0, 0));
        send_pair(build_pair(32'h0, 32'hFFFF_FFFF, 0, 0, 64, 64, 500, 16, 64, 64, 0, 0));
        // swapped ids form a distinct pair
        send_pair(build_pair(32'hFFFF_FFFF, 32'h0, 0, 0, 64, 64, 16, 16, 64, 64, 0, 0));
        // right dead only while in contact
        send_pair(build_pair(32'hFFFF_FFFF, 32'h0, 0, 0, 64, 64, 16, 16, 64, 64, 0, 1));
        // zero sizes at the same centre never touch
        send_pair(build_pair(32'hA5A5_A5A5, 32'h5A5A_5A5A, 7, 7, 0, 0, 7, 7, 0, 0, 0, 0));
        send_pair(build_pair(32'hA5A5_A5A5, 32'h5A5A_5A5A, 7, 7, 1, 1, 7, 7, 0, 0, 0, 0));
        // twice the gap equal to the size sum is not contact, one less is
        send_pair(build_pair(32'h10, 32'h20, 0, 0, 5, 100, 5, 0, 5, 100, 0, 0));
        send_pair(build_pair(32'h10, 32'h20, 0, 0, 5, 100, 5, 0, 6, 100, 0, 0));
        send_pair(build_pair(32'h10, 32'h20, 0, 0, 100, 5, 0, 16'hFFFB, 100, 6, 0, 0));
        send_pair(build_pair(32'h10, 32'h20, 0, 0, 100, 5, 0, 16'hFFFB, 100, 5, 0, 0));
        // full coordinate span with the largest sizes
        send_pair(build_pair(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h8000, 16'hFFFF,
                             16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 0, 0));
        send_pair(build_pair(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h8000, 16'hFFFF,
                             16'hFFFF, 16'h7FFE, 16'h7FFE, 16'hFFFF, 16'hFFFF, 0, 0));
        send_pair(build_pair(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                             16'hFFFF, 16'h8000, 16'h7FFE, 16'hFFFF, 16'hFFFF, 0, 0));
        // overlap with both dead on a fresh pair
        send_pair(build_pair(32'h3, 32'h4, 0, 0, 32, 32, 0, 0, 32, 32, 1, 1));
        send_pair(build_pair(32'h3, 32'h4, 0, 0, 32, 32, 0, 0, 32, 32, 0, 0));
    endtask

    // random geometry over a fixed set of pairs so each pair sees long histories
    task automatic test_pair_pool(int n);
        int k;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_left[i]  = $urandom;
            pool_right[i] = $urandom;
            if (pool_left[i] == pool_right[i])
                pool_right[i] = ~pool_left[i];
        end
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, POOL_SIZE - 1);
            if ($urandom_range(0, 19) == 0)
                send_pair(random_pair(pool_left[k], pool_left[k]));
            else
                send_pair(random_pair(pool_left[k], pool_right[k]));
        end
    endtask

    // fresh pairs fill the table; later fresh pairs are flagged, known ones still tracked
    task automatic test_table_overflow(int n);
        int             k;
        collider_pair_t rejected;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, POOL_SIZE - 1);
            if ($urandom_range(0, 1) == 0)
                send_pair(random_pair($urandom, $urandom));
            else
                send_pair(random_pair(pool_left[k], pool_right[k]));
        end
        // a rejected pair is flagged each time it comes back
        rejected = random_pair(32'hDEAD_0001, 32'hDEAD_0002);
        repeat (3) send_pair(rejected);
    endtask

    // back-to-back traffic with both sides always ready
    task automatic test_no_idle(int n);
        int k;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, POOL_SIZE - 1);
            if ($urandom_range(0, 4) == 0)
                send_pair(random_pair($urandom, $urandom));
            else
                send_pair(random_pair(pool_left[k], pool_right[k]));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pair_pool(300);
        drain_results();
        test_table_overflow(150);
        test_no_idle(120);
        drain_results();
        repeat (MAX_LATENCY + 8) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        $display("sent %0d pairs, %0d tracked; events none/enter/stay/exit = %0d/%0d/%0d/%0d",
                 pairs_sent, tracked_keys.size(), events_seen[0], events_seen[1],
                 events_seen[2], events_seen[3]);
        $display("table-full flags: %0d, mismatches: %0d", full_flags, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result side stalls in random bursts
    always @(posedge clk)
    begin
        if (sink_gap > 0)
        begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else if (sink_idle_en && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            sink_gap <= $urandom_range(0, 8);
        end
        else
            m_tready <= 1'b1;
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        contact_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            events_seen[m_tdata[EVENT_W-1:0]]++;
            if (m_tuser[0])
                full_flags++;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result event=%0d full=%0b",
                                          m_tdata[EVENT_W-1:0], m_tuser[0]));
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[EVENT_W-1:0] !== want.ev || m_tuser[0] !== want.full)
                    report_mismatch($sformatf(
                        "expected event=%s full=%0b, got event=%0d full=%0b",
                        want.ev.name(), want.full, m_tdata[EVENT_W-1:0], m_tuser[0]));
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_MAX);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

[files.f]
src/acpt_pkg.sv
src/acpt_ram.sv
src/acpt_ctrl.sv
src/acpt_dpath.sv
src/aabb_contact_pair_tracker.sv
test/tb_top.sv
